### hdl/spu8_pkg.sv
// shared types and constants for the string pool utf-8 checker
// used by the front, the queue, the back end and the top level
`default_nettype none

package spu8_pkg;

  localparam int unsigned QueueDepth = 2;
  localparam int unsigned QueuePtrW  = (QueueDepth > 1) ? $clog2(QueueDepth) : 1;
  localparam int unsigned QueueCntW  = $clog2(QueueDepth + 1);

  localparam logic [31:0] PoolSizeReset      = 32'd4;
  localparam logic [31:0] ExpectedCountReset = 32'd0;

  // configuration register indexes
  localparam logic CfgPoolSize      = 1'b0;
  localparam logic CfgExpectedCount = 1'b1;

  typedef enum logic [1:0] {
    StatusOk     = 2'd0,
    StatusString = 2'd1,
    StatusUtf8   = 2'd2
  } status_e;

  // one pool byte as classified by the front
  typedef struct packed {
    logic [7:0]  data;
    logic        last;   // final byte of the pool
    logic        late;   // byte already lies past the pool end
    logic [31:0] room;   // pool bytes still to come after this one
  } entry_t;

endpackage

`default_nettype wire

### hdl/spu8_front.sv
// front end: accepts pool bytes, tracks the pool position and tags each byte
// depends on spu8_pkg
`default_nettype none

module spu8_front (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic [31:0]   pool_size_i,
  input  wire logic          data_valid_i,
  input  wire logic [7:0]    data_byte_i,
  output logic               data_stall_o,
  input  wire logic          q_full_i,
  output logic               q_push_o,
  output spu8_pkg::entry_t   q_entry_o
);
  import spu8_pkg::*;

  // position of the next byte, counted from one
  logic [32:0] pos_q, pos_d;
  logic [32:0] size_eff;
  logic [33:0] diff;
  logic        last;

  assign data_stall_o = q_full_i;
  assign q_push_o     = data_valid_i && !q_full_i;

  assign size_eff = {(pool_size_i == 32'd0), pool_size_i};
  assign diff     = {1'b0, size_eff} - {1'b0, pos_q};
  assign last     = (pos_q[31:0] == pool_size_i);

  assign q_entry_o.data = data_byte_i;
  assign q_entry_o.last = last;
  assign q_entry_o.late = diff[33];
  assign q_entry_o.room = diff[31:0];

  always_comb begin
    pos_d = pos_q;
    if (q_push_o) begin
      if (last) begin
        pos_d = 33'd1;
      end else begin
        pos_d = {1'b0, pos_q[31:0]} + 33'd1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q <= 33'd1;
    end else begin
      pos_q <= pos_d;
    end
  end

endmodule

`default_nettype wire

### hdl/spu8_queue.sv
// short register queue between the front and the back end
// depends on spu8_pkg
`default_nettype none

module spu8_queue (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              push_i,
  input  wire spu8_pkg::entry_t  push_entry_i,
  output logic                   full_o,
  input  wire logic              pop_i,
  output logic                   valid_o,
  output spu8_pkg::entry_t       pop_entry_o
);
  import spu8_pkg::*;

  entry_t                 slot_q [QueueDepth];
  logic [QueuePtrW-1:0]   wr_ptr_q, wr_ptr_d;
  logic [QueuePtrW-1:0]   rd_ptr_q, rd_ptr_d;
  logic [QueueCntW-1:0]   cnt_q, cnt_d;
  logic                   do_push, do_pop;

  assign full_o      = (cnt_q == QueueCntW'(QueueDepth));
  assign valid_o     = (cnt_q != '0);
  assign pop_entry_o = slot_q[rd_ptr_q];
  assign do_push     = push_i && !full_o;
  assign do_pop      = pop_i && valid_o;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == QueuePtrW'(QueueDepth - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == QueuePtrW'(QueueDepth - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      slot_q[wr_ptr_q] <= push_entry_i;
    end
  end

endmodule

`default_nettype wire

### hdl/spu8_back.sv
// back end: string framing, strict utf-8 decoding, first-error capture and
// the per-pool result register; depends on spu8_pkg
`default_nettype none

module spu8_back (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic [31:0]       expected_count_i,
  input  wire logic              q_valid_i,
  input  wire spu8_pkg::entry_t  q_entry_i,
  output logic                   q_pop_o,
  output logic                   res_valid_o,
  output logic [1:0]             status_o,
  output logic [31:0]            string_count_o,
  input  wire logic              res_stall_i
);
  import spu8_pkg::*;

  typedef enum logic [1:0] {
    PhLength = 2'd0,
    PhBody   = 2'd1,
    PhPad    = 2'd2
  } phase_e;

  phase_e      ph_q, ph_d;
  logic [1:0]  fpos_q, fpos_d;
  logic [31:0] slen_q, slen_d;
  logic [31:0] brem_q, brem_d;
  logic [1:0]  prem_q, prem_d;
  logic [1:0]  srem_q, srem_d;
  logic [2:0]  stot_q, stot_d;
  logic [20:0] acc_q, acc_d;
  logic [31:0] seen_q, seen_d;
  status_e     err_q, err_d;
  logic        povf_q, povf_d;

  logic        res_valid_q, res_valid_d;
  status_e     status_q, status_d;
  logic [31:0] count_q, count_d;

  logic [7:0]  b;
  logic [20:0] acc_new;
  logic [31:0] len_full;
  logic [1:0]  pad;

  assign q_pop_o        = q_valid_i && (!res_valid_q || !res_stall_i);
  assign res_valid_o    = res_valid_q;
  assign status_o       = status_q;
  assign string_count_o = count_q;

  assign b        = q_entry_i.data;
  assign acc_new  = {acc_q[14:0], b[5:0]};
  assign len_full = {b, slen_q[23:0]};
  assign pad      = 2'd0 - len_full[1:0];

  always_comb begin
    ph_d        = ph_q;
    fpos_d      = fpos_q;
    slen_d      = slen_q;
    brem_d      = brem_q;
    prem_d      = prem_q;
    srem_d      = srem_q;
    stot_d      = stot_q;
    acc_d       = acc_q;
    seen_d      = seen_q;
    err_d       = err_q;
    povf_d      = povf_q;
    res_valid_d = res_valid_q && res_stall_i;
    status_d    = status_q;
    count_d     = count_q;

    if (q_pop_o) begin
      if (err_q == StatusOk) begin
        unique case (ph_q)
          PhLength: begin
            unique case (fpos_q)
              2'd0: slen_d = {24'd0, b};
              2'd1: slen_d = {slen_q[31:16], b, slen_q[7:0]};
              2'd2: slen_d = {slen_q[31:24], b, slen_q[15:0]};
              default: slen_d = len_full;
            endcase
            fpos_d = fpos_q + 2'd1;
            if (fpos_q == 2'd3) begin
              if (q_entry_i.late || (len_full > q_entry_i.room)) begin
                err_d = StatusString;
              end else begin
                povf_d = q_entry_i.late ||
                         (({1'b0, len_full} + {31'd0, pad}) > {1'b0, q_entry_i.room});
                brem_d = len_full;
                prem_d = pad;
                srem_d = 2'd0;
                stot_d = 3'd0;
                acc_d  = '0;
                ph_d   = PhBody;
                // empty string: no sequence open, so padding decides
                if (len_full == 32'd0) begin
                  if (povf_d) begin
                    err_d = StatusString;
                  end else if (pad == 2'd0) begin
                    seen_d = seen_q + 32'd1;
                    ph_d   = PhLength;
                  end else begin
                    ph_d = PhPad;
                  end
                end
              end
            end
          end
          PhBody: begin
            if (srem_q == 2'd0) begin
              if (!b[7]) begin
                // plain ascii
              end else if (b[7:5] == 3'b110) begin
                acc_d = {16'd0, b[4:0]};
                if (b[4:1] == 4'd0) begin
                  err_d = StatusUtf8;
                end else begin
                  stot_d = 3'd2;
                  srem_d = 2'd1;
                end
              end else if (b[7:4] == 4'b1110) begin
                acc_d  = {17'd0, b[3:0]};
                stot_d = 3'd3;
                srem_d = 2'd2;
              end else if (b[7:3] == 5'b11110) begin
                acc_d  = {18'd0, b[2:0]};
                stot_d = 3'd4;
                srem_d = 2'd3;
              end else begin
                err_d = StatusUtf8;
              end
            end else if (b[7:6] != 2'b10) begin
              err_d = StatusUtf8;
            end else begin
              acc_d  = acc_new;
              srem_d = srem_q - 2'd1;
              if (srem_q == 2'd1) begin
                if ((stot_q == 3'd3) && (acc_new < 21'h000800)) begin
                  err_d = StatusUtf8;
                end else if ((stot_q == 3'd4) &&
                             ((acc_new < 21'h010000) || (acc_new > 21'h10FFFF))) begin
                  err_d = StatusUtf8;
                end else if ((acc_new >= 21'h00D800) && (acc_new <= 21'h00DFFF)) begin
                  err_d = StatusUtf8;
                end
              end
            end
            if (err_d == StatusOk) begin
              brem_d = brem_q - 32'd1;
              if (brem_q == 32'd1) begin
                if (srem_d != 2'd0) begin
                  err_d = StatusUtf8;
                end else if (povf_q) begin
                  err_d = StatusString;
                end else if (prem_q == 2'd0) begin
                  seen_d = seen_q + 32'd1;
                  ph_d   = PhLength;
                end else begin
                  ph_d = PhPad;
                end
              end
            end
          end
          PhPad: begin
            if (b != 8'd0) begin
              err_d = StatusString;
            end else begin
              prem_d = prem_q - 2'd1;
              if (prem_q == 2'd1) begin
                seen_d = seen_q + 32'd1;
                ph_d   = PhLength;
              end
            end
          end
          default: begin
            ph_d = PhLength;
          end
        endcase
      end

      if (q_entry_i.last) begin
        // pool ends: framing left open, then the count check
        if ((err_d == StatusOk) && ((ph_d != PhLength) || (fpos_d != 2'd0))) begin
          err_d = StatusString;
        end
        if ((err_d == StatusOk) && (seen_d != expected_count_i)) begin
          err_d = StatusString;
        end
        res_valid_d = 1'b1;
        status_d    = err_d;
        count_d     = seen_d;
        ph_d        = PhLength;
        fpos_d      = 2'd0;
        slen_d      = '0;
        brem_d      = '0;
        prem_d      = 2'd0;
        srem_d      = 2'd0;
        stot_d      = 3'd0;
        acc_d       = '0;
        seen_d      = '0;
        err_d       = StatusOk;
        povf_d      = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ph_q        <= PhLength;
      fpos_q      <= 2'd0;
      slen_q      <= '0;
      brem_q      <= '0;
      prem_q      <= 2'd0;
      srem_q      <= 2'd0;
      stot_q      <= 3'd0;
      acc_q       <= '0;
      seen_q      <= '0;
      err_q       <= StatusOk;
      povf_q      <= 1'b0;
      res_valid_q <= 1'b0;
      status_q    <= StatusOk;
      count_q     <= '0;
    end else begin
      ph_q        <= ph_d;
      fpos_q      <= fpos_d;
      slen_q      <= slen_d;
      brem_q      <= brem_d;
      prem_q      <= prem_d;
      srem_q      <= srem_d;
      stot_q      <= stot_d;
      acc_q       <= acc_d;
      seen_q      <= seen_d;
      err_q       <= err_d;
      povf_q      <= povf_d;
      res_valid_q <= res_valid_d;
      status_q    <= status_d;
      count_q     <= count_d;
    end
  end

endmodule

`default_nettype wire

### hdl/string_pool_utf8_checker_unit.sv
// top level of the string pool utf-8 checker: configuration registers,
// front end, queue and back end; depends on spu8_pkg and the spu8_* modules
//
//   channel   direction  handshake                 payload
//   data      in         data_valid_i/data_stall_o data_byte_i
//   result    out        res_valid_o/res_stall_i   status_o, string_count_o
//   config    in         cfg_we_i                  cfg_index_i, cfg_wdata_i
//
// one byte is taken every cycle while the two-entry queue has room; the back end
// retires one queued byte per cycle unless a result waits, so sustained rate is
// one byte a cycle; a result is registered when the last byte of a pool leaves
// the queue; the back end holds while a result waits, and the queue then fills
// and stalls the input; reset gives pool_size 4, expected_count 0 and an empty pool
`default_nettype none

module string_pool_utf8_checker_unit (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        data_valid_i,
  input  wire logic [7:0]  data_byte_i,
  output logic             data_stall_o,
  output logic             res_valid_o,
  output logic [1:0]       status_o,
  output logic [31:0]      string_count_o,
  input  wire logic        res_stall_i,
  input  wire logic        cfg_we_i,
  input  wire logic        cfg_index_i,
  input  wire logic [31:0] cfg_wdata_i
);
  import spu8_pkg::*;

  logic [31:0] pool_size_q, pool_size_d;
  logic [31:0] expected_q, expected_d;

  logic   q_push, q_full, q_pop, q_valid;
  entry_t push_entry, pop_entry;

  always_comb begin
    pool_size_d = pool_size_q;
    expected_d  = expected_q;
    if (cfg_we_i) begin
      unique case (cfg_index_i)
        CfgPoolSize:      pool_size_d = cfg_wdata_i;
        CfgExpectedCount: expected_d  = cfg_wdata_i;
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pool_size_q <= PoolSizeReset;
      expected_q  <= ExpectedCountReset;
    end else begin
      pool_size_q <= pool_size_d;
      expected_q  <= expected_d;
    end
  end

  spu8_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .pool_size_i  (pool_size_q),
    .data_valid_i (data_valid_i),
    .data_byte_i  (data_byte_i),
    .data_stall_o (data_stall_o),
    .q_full_i     (q_full),
    .q_push_o     (q_push),
    .q_entry_o    (push_entry)
  );

  spu8_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (q_push),
    .push_entry_i (push_entry),
    .full_o       (q_full),
    .pop_i        (q_pop),
    .valid_o      (q_valid),
    .pop_entry_o  (pop_entry)
  );

  spu8_back u_back (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .expected_count_i (expected_q),
    .q_valid_i        (q_valid),
    .q_entry_i        (pop_entry),
    .q_pop_o          (q_pop),
    .res_valid_o      (res_valid_o),
    .status_o         (status_o),
    .string_count_o   (string_count_o),
    .res_stall_i      (res_stall_i)
  );

endmodule

`default_nettype wire

### dv/tb_top.sv
// testbench for the string pool utf-8 checker: directed pools from a table,
// then random pools, each result checked against an in-bench pool predictor
// depends on spu8_pkg and string_pool_utf8_checker_unit
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import spu8_pkg::*;

  typedef enum logic [1:0] {
    InLength,
    InBody,
    InPad
  } walk_e;

  typedef struct packed {
    status_e     status;
    logic [31:0] strings;
  } pool_report_t;

  // one directed pool: register values (pool length 0 leaves them alone),
  // bytes in order from the top of seq, and an optional hand-typed report
  typedef struct packed {
    logic [31:0]  psize;
    logic [31:0]  ecount;
    logic [7:0]   n;
    logic [95:0]  seq;
    logic         fixed;
    pool_report_t rep;
  } probe_row_t;

  localparam int WatchdogLimit = 3000;
  localparam int LongHold      = 90;
  localparam int RandomBytes   = 1550;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        data_valid = 1'b0;
  logic [7:0]  data_byte = 8'd0;
  logic        data_stall;
  logic        res_valid;
  logic [1:0]  res_status;
  logic [31:0] res_strings;
  logic        res_stall = 1'b0;
  logic        cfg_we = 1'b0;
  logic        cfg_index = CfgPoolSize;
  logic [31:0] cfg_wdata = 32'd0;

  string_pool_utf8_checker_unit DUT (
    .clk_i          (clk),
    .rst_ni         (rst_n),
    .data_valid_i   (data_valid),
    .data_byte_i    (data_byte),
    .data_stall_o   (data_stall),
    .res_valid_o    (res_valid),
    .status_o       (res_status),
    .string_count_o (res_strings),
    .res_stall_i    (res_stall),
    .cfg_we_i       (cfg_we),
    .cfg_index_i    (cfg_index),
    .cfg_wdata_i    (cfg_wdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // register copies and pool walk state of the predictor
  logic [31:0] cfg_pool_len     = PoolSizeReset;
  logic [31:0] cfg_want_strings = ExpectedCountReset;
  walk_e       p_walk;
  logic [31:0] p_offset;
  logic [1:0]  p_lenpos;
  logic [31:0] p_strlen;
  logic [31:0] p_body_left;
  logic [1:0]  p_pad_left;
  logic [1:0]  p_cont_left;
  logic [2:0]  p_cp_bytes;
  logic [20:0] p_cp;
  logic [31:0] p_strings;
  status_e     p_err;
  logic        p_pad_spill;

  pool_report_t pending_reports[$];
  probe_row_t   probes[$];
  logic [7:0]   pool_q[$];
  int           fail_count = 0;
  int           idle_cycles = 0;
  bit           burst = 1'b0;
  bit           long_hold_req = 1'b0;

  function automatic void restart_pool();
    p_walk      = InLength;
    p_offset    = '0;
    p_lenpos    = '0;
    p_strlen    = '0;
    p_body_left = '0;
    p_pad_left  = '0;
    p_cont_left = '0;
    p_cp_bytes  = '0;
    p_cp        = '0;
    p_strings   = '0;
    p_err       = StatusOk;
    p_pad_spill = 1'b0;
  endfunction

  function automatic void decode_utf8(input logic [7:0] b);
    if (p_cont_left == 2'd0) begin
      if (b < 8'h80) return;
      if ((b & 8'hE0) == 8'hC0) begin
        p_cp = 21'(b & 8'h1F);
        // c0 and c1 can only start overlong forms
        if (p_cp < 21'd2) begin
          p_err = StatusUtf8;
          return;
        end
        p_cp_bytes = 3'd2;
      end else if ((b & 8'hF0) == 8'hE0) begin
        p_cp = 21'(b & 8'h0F);
        p_cp_bytes = 3'd3;
      end else if ((b & 8'hF8) == 8'hF0) begin
        p_cp = 21'(b & 8'h07);
        p_cp_bytes = 3'd4;
      end else begin
        p_err = StatusUtf8;
        return;
      end
      p_cont_left = 2'(p_cp_bytes - 3'd1);
      return;
    end
    if ((b & 8'hC0) != 8'h80) begin
      p_err = StatusUtf8;
      return;
    end
    p_cp = {p_cp[14:0], b[5:0]};
    p_cont_left = p_cont_left - 2'd1;
    if (p_cont_left != 2'd0) return;
    if (p_cp_bytes == 3'd3 && p_cp < 21'h800) p_err = StatusUtf8;
    else if (p_cp_bytes == 3'd4 && (p_cp < 21'h10000 || p_cp > 21'h10FFFF)) p_err = StatusUtf8;
    else if (p_cp >= 21'hD800 && p_cp <= 21'hDFFF) p_err = StatusUtf8;
  endfunction

  function automatic void finish_text();
    if (p_cont_left != 2'd0) p_err = StatusUtf8;
    else if (p_pad_spill) p_err = StatusString;
    else if (p_pad_left == 2'd0) begin
      p_strings = p_strings + 32'd1;
      p_walk = InLength;
    end else p_walk = InPad;
  endfunction

  function automatic void absorb_byte(input logic [7:0] b);
    logic [63:0] span;
    logic [63:0] limit;
    logic [1:0]  pad;
    case (p_walk)
      InLength: begin
        if (p_lenpos == 2'd0) p_strlen = '0;
        p_strlen[8*p_lenpos +: 8] = b;
        p_lenpos = p_lenpos + 2'd1;
        if (p_lenpos != 2'd0) return;
        span  = 64'(p_offset) + 64'd1 + 64'(p_strlen);
        limit = (cfg_pool_len == '0) ? 64'h1_0000_0000 : 64'(cfg_pool_len);
        pad   = 2'd0 - p_strlen[1:0];
        // a body running past the pool end fails before any of it is seen
        if (span > limit) begin
          p_err = StatusString;
          return;
        end
        p_pad_spill = (span + 64'(pad)) > limit;
        p_body_left = p_strlen;
        p_pad_left  = pad;
        p_cont_left = '0;
        p_cp_bytes  = '0;
        p_cp        = '0;
        p_walk      = InBody;
        if (p_body_left == '0) finish_text();
      end
      InBody: begin
        decode_utf8(b);
        if (p_err != StatusOk) return;
        p_body_left = p_body_left - 32'd1;
        if (p_body_left == '0) finish_text();
      end
      default: begin
        if (b != 8'd0) begin
          p_err = StatusString;
          return;
        end
        p_pad_left = p_pad_left - 2'd1;
        if (p_pad_left == 2'd0) begin
          p_strings = p_strings + 32'd1;
          p_walk = InLength;
        end
      end
    endcase
  endfunction

  function automatic bit predict_byte(input logic [7:0] b, output pool_report_t rep);
    bit at_end;
    if (p_err == StatusOk) absorb_byte(b);
    at_end = (p_offset + 32'd1) == cfg_pool_len;
    p_offset = p_offset + 32'd1;
    rep = '0;
    if (!at_end) return 1'b0;
    if (p_err == StatusOk && (p_walk != InLength || p_lenpos != 2'd0)) p_err = StatusString;
    if (p_err == StatusOk && p_strings != cfg_want_strings) p_err = StatusString;
    rep.status  = p_err;
    rep.strings = p_strings;
    restart_pool();
    return 1'b1;
  endfunction

  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (burst || r < 55) return 0;
    if (r < 94) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic void add_probe(input logic [31:0] psize, input logic [31:0] ecount,
                                    input logic [7:0] n, input logic [95:0] seq,
                                    input logic fixed, input status_e st,
                                    input logic [31:0] strings);
    probe_row_t row;
    row.psize       = psize;
    row.ecount      = ecount;
    row.n           = n;
    row.seq         = seq;
    row.fixed       = fixed;
    row.rep.status  = st;
    row.rep.strings = strings;
    probes.push_back(row);
  endfunction

  // the expected report is queued before the byte is offered, which is safe
  // as no result can come out ahead of its last byte
  task automatic send_pool_byte(input logic [7:0] b, input logic fixed,
                                input pool_report_t fixed_rep);
    pool_report_t rep;
    int gap;
    if (predict_byte(b, rep)) pending_reports.push_back(fixed ? fixed_rep : rep);
    gap = gap_len();
    if (gap > 0) begin
      data_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    data_valid <= 1'b1;
    data_byte  <= b;
    @(posedge clk);
    while (data_stall) @(posedge clk);
  endtask

  // drain the block; spare cycles after the last result cover bytes with no result
  task automatic settle();
    data_valid <= 1'b0;
    while (pending_reports.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic load_regs(input logic [31:0] psize, input logic [31:0] ecount);
    cfg_we    <= 1'b1;
    cfg_index <= CfgPoolSize;
    cfg_wdata <= psize;
    @(posedge clk);
    cfg_index <= CfgExpectedCount;
    cfg_wdata <= ecount;
    @(posedge clk);
    cfg_we <= 1'b0;
    cfg_pool_len     = psize;
    cfg_want_strings = ecount;
  endtask

  task automatic put_text(input int n);
    int          k;
    logic [20:0] cp;
    while (n > 0) begin
      k = $urandom_range(1, (n < 4) ? n : 4);
      case (k)
        1: pool_q.push_back(8'($urandom_range(0, 127)));
        2: begin
          cp = 21'($urandom_range(16'h80, 16'h7FF));
          pool_q.push_back(8'(8'hC0 | (cp >> 6)));
          pool_q.push_back(8'(8'h80 | (cp & 21'h3F)));
        end
        3: begin
          cp = 21'($urandom_range(16'h800, 16'hFFFF));
          // move surrogates up into the private range
          if (cp >= 21'hD800 && cp <= 21'hDFFF) cp = cp ^ 21'h3000;
          pool_q.push_back(8'(8'hE0 | (cp >> 12)));
          pool_q.push_back(8'(8'h80 | ((cp >> 6) & 21'h3F)));
          pool_q.push_back(8'(8'h80 | (cp & 21'h3F)));
        end
        default: begin
          cp = 21'($urandom_range(32'h10000, 32'h10FFFF));
          pool_q.push_back(8'(8'hF0 | (cp >> 18)));
          pool_q.push_back(8'(8'h80 | ((cp >> 12) & 21'h3F)));
          pool_q.push_back(8'(8'h80 | ((cp >> 6) & 21'h3F)));
          pool_q.push_back(8'(8'h80 | (cp & 21'h3F)));
        end
      endcase
      n = n - k;
    end
  endtask

  // result side: stall pattern, with a long hold when asked for
  initial begin : result_stalls
    int stall_left;
    int r;
    stall_left = 0;
    forever begin
      @(posedge clk);
      r = $urandom_range(0, 99);
      if (stall_left > 0) begin
        stall_left = stall_left - 1;
        res_stall <= 1'b1;
      end else if (long_hold_req) begin
        long_hold_req = 1'b0;
        stall_left = LongHold;
        res_stall <= 1'b1;
      end else if (burst || r < 70) begin
        res_stall <= 1'b0;
      end else begin
        stall_left = (r < 97) ? $urandom_range(0, 2) : $urandom_range(15, 40);
        res_stall <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin : result_check
    pool_report_t want;
    if (rst_n) begin
      if ((res_valid && !res_stall) || (data_valid && !data_stall)) idle_cycles = 0;
      else idle_cycles = idle_cycles + 1;
      if (res_valid && !res_stall) begin
        if (pending_reports.size() == 0) begin
          $error("unexpected result transfer: status %0d string_count %0d",
                 res_status, res_strings);
          fail_count = fail_count + 1;
        end else begin
          want = pending_reports.pop_front();
          if (res_status !== want.status) begin
            $error("status: expected %0d, got %0d", want.status, res_status);
            fail_count = fail_count + 1;
          end
          if (res_strings !== want.strings) begin
            $error("string_count: expected %0d, got %0d", want.strings, res_strings);
            fail_count = fail_count + 1;
          end
        end
      end
      if (idle_cycles >= WatchdogLimit) begin
        $display("CHECK FAILED");
        $finish;
      end
    end
  end

  initial begin : stimulus
    probe_row_t row;
    logic [31:0] psize;
    logic [31:0] ecount;
    int lens[4];
    int nstr;
    int npools;
    int total;
    int r;
    int rnd_bytes;
    int phase_no;
    bit hold;
    pool_report_t no_rep;

    no_rep = '0;
    restart_pool();

    // after reset, register extremes, every length of utf-8 sequence,
    // each kind of utf-8 fault, framing faults and a write in mid pool
    add_probe(0, 0, 4, 96'h00000000_00000000_00000000, 1, StatusString, 1);
    add_probe(4, 1, 4, 96'h00000000_00000000_00000000, 1, StatusOk, 1);
    add_probe(1, 0, 1, 96'h00000000_00000000_00000000, 1, StatusString, 0);
    add_probe(8, 1, 8, 96'h01000000_41000000_00000000, 0, StatusOk, 0);
    add_probe(8, 1, 8, 96'h01000000_FF000000_00000000, 1, StatusUtf8, 0);
    add_probe(8, 1, 8, 96'h02000000_C0800000_00000000, 0, StatusOk, 0);
    add_probe(8, 1, 8, 96'h03000000_EDA08000_00000000, 0, StatusOk, 0);
    add_probe(8, 1, 8, 96'h04000000_F4908080_00000000, 0, StatusOk, 0);
    add_probe(8, 1, 8, 96'h04000000_F48FBFBF_00000000, 0, StatusOk, 0);
    add_probe(12, 2, 12, 96'h02000000_C2800000_00000000, 0, StatusOk, 0);
    add_probe(12, 1, 12, 96'h07000000_E0A080F0_90808000, 0, StatusOk, 0);
    add_probe(8, 1, 8, 96'h03000000_E09FBF00_00000000, 0, StatusOk, 0);
    add_probe(8, 1, 8, 96'h02000000_E2410000_00000000, 0, StatusOk, 0);
    add_probe(8, 1, 8, 96'h01000000_E2000000_00000000, 0, StatusOk, 0);
    add_probe(8, 1, 8, 96'h01000000_41000700_00000000, 1, StatusString, 0);
    add_probe(5, 1, 5, 96'h01000000_41000000_00000000, 1, StatusString, 0);
    add_probe(6, 0, 6, 96'h00000000_00000000_00000000, 1, StatusString, 1);
    add_probe(32'hFFFF_FFFF, 32'hFFFF_FFFF, 6, 96'hFFFFFFFF_80FE0000_00000000,
              0, StatusOk, 0);
    add_probe(10, 0, 4, 96'h00000000_00000000_00000000, 1, StatusString, 0);

    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (probes[i]) begin
      row = probes[i];
      if (row.psize != '0) begin
        settle();
        load_regs(row.psize, row.ecount);
      end
      for (int j = 0; j < row.n; j++) send_pool_byte(row.seq[95-8*j -: 8], row.fixed, row.rep);
    end

    rnd_bytes = 0;
    phase_no = 0;
    while (rnd_bytes < RandomBytes) begin
      phase_no = phase_no + 1;
      hold = (phase_no % 12) == 1;
      if (!hold && $urandom_range(0, 6) == 0) begin
        // pure noise pools, including the shortest ones
        psize  = $urandom_range(1, 24);
        ecount = $urandom_range(0, 2);
        npools = $urandom_range(1, 4);
      end else begin
        nstr = $urandom_range(1, 4);
        total = 0;
        for (int i = 0; i < nstr; i++) begin
          lens[i] = ($urandom_range(0, 9) == 0) ? $urandom_range(11, 60) : $urandom_range(0, 10);
          total = total + 4 + lens[i] + ((4 - lens[i] % 4) % 4);
        end
        psize = total;
        r = $urandom_range(0, 9);
        if (r == 0) psize = total + $urandom_range(1, 3);
        else if (r == 1 && total > 4) psize = total - $urandom_range(1, 3);
        ecount = nstr;
        if ($urandom_range(0, 9) == 0) ecount = $urandom_range(0, 5);
        npools = hold ? 4 : $urandom_range(1, 3);
      end
      settle();
      burst = hold || ($urandom_range(0, 4) == 0);
      load_regs(psize, ecount);
      // sender keeps offering while the result side holds off
      if (hold) long_hold_req = 1'b1;
      repeat (npools) begin
        pool_q = {};
        if (nstr == 0) begin
          repeat (psize) pool_q.push_back(8'($urandom));
        end else begin
          for (int i = 0; i < nstr; i++) begin
            for (int k = 0; k < 4; k++) pool_q.push_back(8'(lens[i] >> (8 * k)));
            put_text(lens[i]);
            repeat ((4 - lens[i] % 4) % 4) pool_q.push_back(8'd0);
          end
          while (pool_q.size() > psize) pool_q.pop_back();
          while (pool_q.size() < psize) pool_q.push_back(8'($urandom));
          if ($urandom_range(0, 4) == 0) pool_q[$urandom_range(0, psize - 1)] = 8'($urandom);
        end
        foreach (pool_q[i]) send_pool_byte(pool_q[i], 1'b0, no_rep);
        rnd_bytes = rnd_bytes + pool_q.size();
      end
      nstr = 0;
    end

    settle();
    repeat (6) @(posedge clk);
    if (fail_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
